// ===== rtl/core/krb_pkg.sv =====
// krb_pkg: shared widths, action codes and rounding helpers for the
// reach bounds block. No dependencies.
`timescale 1ns / 1ps
package krb_pkg;

  localparam int unsigned QW   = 24;
  localparam int unsigned PW   = 32;
  localparam int unsigned AW   = 64;
  localparam int unsigned MBW  = 26;
  localparam int unsigned DNW  = 50;
  localparam int unsigned DDW  = 26;

  typedef logic [QW-1:0]         q24_t;
  typedef logic signed [PW-1:0]  pos_t;
  typedef logic signed [AW-1:0]  acc_t;

  localparam logic [1:0] ACT_INIT   = 2'd0;
  localparam logic [1:0] ACT_QUERY  = 2'd1;
  localparam logic [1:0] ACT_UPDATE = 2'd2;

  localparam logic [1:0] REG_ACCEL = 2'd0;
  localparam logic [1:0] REG_DECEL = 2'd1;
  localparam logic [1:0] REG_SPEED = 2'd2;

  localparam q24_t ACCEL_RST = 24'd131072;
  localparam q24_t DECEL_RST = 24'd262144;
  localparam q24_t SPEED_RST = 24'd1310720;

  function automatic acc_t rnd16(input acc_t x);
    rnd16 = (x + 64'sd32768) >>> 16;
  endfunction

  function automatic acc_t rnd17(input acc_t x);
    rnd17 = (x + 64'sd65536) >>> 17;
  endfunction

endpackage

// ===== rtl/core/kinematic_reach_bounds_top.sv =====
// Reach bounds block: lower braking envelope and upper acceleration envelope.
// Uses krb_pkg for widths, codes and rounding helpers.
//
// One transaction at a time: in_ready is high only while the sequencer is
// idle. A shift-add multiplier and a restoring divider are shared by both
// sides. A query or update holds in_ready low through the products of both
// sides, plus the stopping division on the lower side and the cruise
// product and division on the upper side when they are needed; an init
// holds it low only while in ST_FIN. ST_FIN stretches while an earlier
// result still waits in the output register; otherwise the next
// transaction is taken while the result waits.
`timescale 1ns / 1ps
module kinematic_reach_bounds_top (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_action,
  input  logic [23:0]          in_query_time,
  input  logic [23:0]          in_initial_speed,
  input  logic signed [31:0]   in_lower_block_pos,
  input  logic signed [31:0]   in_upper_block_pos,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   out_lower_bound,
  output logic signed [31:0]   out_upper_bound,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [23:0]          cfg_wdata
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_MUL    = 4'd1;
  localparam logic [3:0] ST_DIV    = 4'd2;
  localparam logic [3:0] ST_L_GO   = 4'd3;
  localparam logic [3:0] ST_L_CMP  = 4'd4;
  localparam logic [3:0] ST_L_RAMP = 4'd5;
  localparam logic [3:0] ST_L_DIV  = 4'd6;
  localparam logic [3:0] ST_L_DIVF = 4'd7;
  localparam logic [3:0] ST_U_GO   = 4'd8;
  localparam logic [3:0] ST_U_CMP  = 4'd9;
  localparam logic [3:0] ST_U_RAMP = 4'd10;
  localparam logic [3:0] ST_U_X    = 4'd11;
  localparam logic [3:0] ST_U_DIV  = 4'd12;
  localparam logic [3:0] ST_U_DIVF = 4'd13;
  localparam logic [3:0] ST_FIN    = 4'd14;

  logic [3:0] state_r, ret_r, ret_nxt;

  krb_pkg::q24_t accel_r, decel_r, speed_r;
  krb_pkg::q24_t lat_r, lsp_r, uat_r, usp_r;
  krb_pkg::pos_t lpos_r, upos_r;

  logic [1:0]    act_r;
  krb_pkg::q24_t t_r, vi_r;
  krb_pkg::pos_t lblk_r, ublk_r;

  krb_pkg::acc_t lo_r, up_r, p1_r, p2_r, x_r;
  logic signed [31:0] out_lo_r, out_up_r;
  logic out_valid_r;

  // shared multiplier
  krb_pkg::acc_t mul_acc_r, mul_a_r;
  logic [krb_pkg::MBW-1:0] mul_b_r;
  logic mul_neg_r;
  logic [4:0] mul_cnt_r;
  krb_pkg::acc_t prod;

  // shared divider
  logic [krb_pkg::DNW-1:0] div_q_r;
  logic [krb_pkg::DDW-1:0] div_rem_r, div_d_r;
  logic [5:0] div_cnt_r;
  logic [krb_pkg::DDW:0] rem_sh;
  logic qbit;
  krb_pkg::acc_t quot;

  logic mul_go, div_go;
  krb_pkg::acc_t mul_x;
  logic signed [krb_pkg::MBW-1:0] mul_y;
  logic [krb_pkg::DNW-1:0] div_n;
  logic [krb_pkg::DDW-1:0] div_d;

  krb_pkg::q24_t dec_eff, acc_eff;
  logic signed [24:0] dt_l, dt_u, e_s;
  krb_pkg::acc_t dtl64, dtu64, e64, v0l64, v0u64, lv, uv;
  logic signed [krb_pkg::MBW-1:0] dtl_y, dtu_y, e_y;

  assign dec_eff = (decel_r == '0) ? 24'd1 : decel_r;
  assign acc_eff = (accel_r == '0) ? 24'd1 : accel_r;
  assign dt_l  = $signed({1'b0, t_r}) - $signed({1'b0, lat_r});
  assign dt_u  = $signed({1'b0, t_r}) - $signed({1'b0, uat_r});
  assign e_s   = $signed({1'b0, speed_r}) - $signed({1'b0, usp_r});
  assign dtl64 = {{39{dt_l[24]}}, dt_l};
  assign dtu64 = {{39{dt_u[24]}}, dt_u};
  assign e64   = {{39{e_s[24]}}, e_s};
  assign dtl_y = {dt_l[24], dt_l};
  assign dtu_y = {dt_u[24], dt_u};
  assign e_y   = {e_s[24], e_s};
  assign v0l64 = {40'd0, lsp_r};
  assign v0u64 = {40'd0, usp_r};

  assign prod = mul_neg_r ? -mul_acc_r : mul_acc_r;
  assign rem_sh = {div_rem_r, div_q_r[krb_pkg::DNW-1]};
  assign qbit = (rem_sh >= {1'b0, div_d_r});
  assign quot = {{(krb_pkg::AW-krb_pkg::DNW){1'b0}}, div_q_r};

  assign lv = v0l64 - krb_pkg::rnd16(p1_r);
  assign uv = v0u64 + krb_pkg::rnd16(p2_r);

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_lower_bound = out_lo_r;
  assign out_upper_bound = out_up_r;

  always_comb begin
    mul_go  = 1'b0;
    div_go  = 1'b0;
    mul_x   = '0;
    mul_y   = '0;
    div_n   = '0;
    div_d   = '0;
    ret_nxt = ST_IDLE;
    unique case (state_r)
      ST_L_GO: begin
        mul_go = 1'b1; mul_x = dtl64; mul_y = {2'b00, dec_eff}; ret_nxt = ST_L_CMP;
      end
      ST_L_CMP: begin
        mul_go = 1'b1;
        if (prod < (v0l64 <<< 16)) begin
          mul_x = krb_pkg::rnd16((v0l64 <<< 17) - prod); mul_y = dtl_y; ret_nxt = ST_L_RAMP;
        end else begin
          mul_x = v0l64; mul_y = {2'b00, lsp_r}; ret_nxt = ST_L_DIV;
        end
      end
      ST_L_DIV: begin
        div_go = 1'b1;
        div_n = krb_pkg::DNW'(prod + {40'd0, dec_eff});
        div_d = {1'b0, dec_eff, 1'b0};
        ret_nxt = ST_L_DIVF;
      end
      ST_U_GO: begin
        mul_go = 1'b1; mul_x = dtu64; mul_y = {2'b00, acc_eff}; ret_nxt = ST_U_CMP;
      end
      ST_U_CMP: begin
        mul_go = 1'b1;
        if (prod < (e64 <<< 16)) begin
          mul_x = krb_pkg::rnd16((v0u64 <<< 17) + prod); mul_y = dtu_y; ret_nxt = ST_U_RAMP;
        end else begin
          mul_x = dtu64; mul_y = {2'b00, speed_r}; ret_nxt = ST_U_X;
        end
      end
      ST_U_X: begin
        mul_go = 1'b1; mul_x = e64; mul_y = e_y; ret_nxt = ST_U_DIV;
      end
      ST_U_DIV: begin
        div_go = 1'b1;
        div_n = krb_pkg::DNW'(prod + {40'd0, acc_eff});
        div_d = {1'b0, acc_eff, 1'b0};
        ret_nxt = ST_U_DIVF;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ret_r       <= ST_IDLE;
      out_valid_r <= 1'b0;
      accel_r     <= krb_pkg::ACCEL_RST;
      decel_r     <= krb_pkg::DECEL_RST;
      speed_r     <= krb_pkg::SPEED_RST;
      lat_r  <= '0; lsp_r <= '0; lpos_r <= '0;
      uat_r  <= '0; usp_r <= '0; upos_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          krb_pkg::REG_ACCEL: accel_r <= cfg_wdata;
          krb_pkg::REG_DECEL: decel_r <= cfg_wdata;
          krb_pkg::REG_SPEED: speed_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid_r && out_ready && (state_r != ST_FIN)) begin
        out_valid_r <= 1'b0;
      end

      if (mul_go) begin
        mul_a_r   <= mul_x[krb_pkg::AW-1] ? -mul_x : mul_x;
        mul_b_r   <= mul_y[krb_pkg::MBW-1] ? -mul_y : mul_y;
        mul_neg_r <= mul_x[krb_pkg::AW-1] ^ mul_y[krb_pkg::MBW-1];
        mul_acc_r <= '0;
        mul_cnt_r <= 5'(krb_pkg::MBW - 1);
        ret_r     <= ret_nxt;
        state_r   <= ST_MUL;
      end
      if (div_go) begin
        div_q_r   <= div_n;
        div_d_r   <= div_d;
        div_rem_r <= '0;
        div_cnt_r <= 6'(krb_pkg::DNW - 1);
        ret_r     <= ret_nxt;
        state_r   <= ST_DIV;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            act_r  <= in_action;
            t_r    <= in_query_time;
            vi_r   <= in_initial_speed;
            lblk_r <= in_lower_block_pos;
            ublk_r <= in_upper_block_pos;
            if (in_action == krb_pkg::ACT_INIT) begin
              lo_r    <= '0;
              up_r    <= '0;
              state_r <= ST_FIN;
            end else begin
              state_r <= ST_L_GO;
            end
          end
        end
        ST_MUL: begin
          mul_acc_r <= mul_b_r[0] ? mul_acc_r + mul_a_r : mul_acc_r;
          mul_a_r   <= mul_a_r << 1;
          mul_b_r   <= mul_b_r >> 1;
          mul_cnt_r <= mul_cnt_r - 5'd1;
          if (mul_cnt_r == '0) begin
            state_r <= ret_r;
          end
        end
        ST_DIV: begin
          div_q_r   <= {div_q_r[krb_pkg::DNW-2:0], qbit};
          div_rem_r <= qbit ? krb_pkg::DDW'(rem_sh - {1'b0, div_d_r})
                            : krb_pkg::DDW'(rem_sh);
          div_cnt_r <= div_cnt_r - 6'd1;
          if (div_cnt_r == '0) begin
            state_r <= ret_r;
          end
        end
        ST_L_CMP: p1_r <= prod;
        ST_L_RAMP: begin
          lo_r    <= {{32{lpos_r[31]}}, lpos_r} + krb_pkg::rnd17(prod);
          state_r <= ST_U_GO;
        end
        ST_L_DIVF: begin
          lo_r    <= {{32{lpos_r[31]}}, lpos_r} + quot;
          state_r <= ST_U_GO;
        end
        ST_U_CMP: p2_r <= prod;
        ST_U_RAMP: begin
          up_r    <= {{32{upos_r[31]}}, upos_r} + krb_pkg::rnd17(prod);
          state_r <= ST_FIN;
        end
        ST_U_X: x_r <= krb_pkg::rnd16(prod);
        ST_U_DIVF: begin
          up_r    <= {{32{upos_r[31]}}, upos_r} + x_r - quot;
          state_r <= ST_FIN;
        end
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (lo_r > 64'sh7fffffff) out_lo_r <= 32'sh7fffffff;
            else if (lo_r < -64'sh80000000) out_lo_r <= 32'sh80000000;
            else out_lo_r <= lo_r[31:0];
            if (up_r > 64'sh7fffffff) out_up_r <= 32'sh7fffffff;
            else if (up_r < -64'sh80000000) out_up_r <= 32'sh80000000;
            else out_up_r <= up_r[31:0];
            if (act_r == krb_pkg::ACT_INIT) begin
              lat_r <= '0; lsp_r <= vi_r; lpos_r <= '0;
              uat_r <= '0; usp_r <= vi_r; upos_r <= '0;
            end else if (act_r == krb_pkg::ACT_UPDATE) begin
              if (lo_r < $signed({{32{lblk_r[31]}}, lblk_r})) begin
                lat_r  <= t_r;
                lpos_r <= lblk_r;
                if (lv < 0) lsp_r <= '0;
                else if (lv > 64'sd16777215) lsp_r <= 24'hffffff;
                else lsp_r <= lv[23:0];
              end
              if (up_r > $signed({{32{ublk_r[31]}}, ublk_r})) begin
                uat_r  <= t_r;
                upos_r <= ublk_r;
                if (uv > $signed({40'd0, speed_r})) usp_r <= speed_r;
                else if (uv < 0) usp_r <= '0;
                else usp_r <= uv[23:0];
              end
            end
            state_r <= ST_IDLE;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
